// ----- rtl/core/sttk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttk_pkg
// Types, constants and key helpers shared by the sorted triple-key table.
// ----------------------------------------------------------------------------
package sttk_pkg;

    localparam int unsigned DefTableDepth = 256;

    localparam int unsigned IdW    = 13;
    localparam int unsigned AmtW   = 8;
    localparam int unsigned ProdW  = 12;
    localparam int unsigned PosW   = 8;
    localparam int unsigned StW    = 2;
    localparam int unsigned SDataW = 80;
    localparam int unsigned MDataW = 48;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [StW-1:0] ST_INSERTED  = 2'd0;
    localparam logic [StW-1:0] ST_FOUND     = 2'd1;
    localparam logic [StW-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [StW-1:0] ST_FULL      = 2'd3;

    localparam logic [IdW-1:0] ID_EMPTY = '1;
    localparam logic [IdW-1:0] ID_MSB   = {1'b1, {(IdW-1){1'b0}}};

    typedef logic [IdW-1:0]  t_id;
    typedef logic [AmtW-1:0] t_amt;
    typedef t_id  [2:0]      t_key;
    typedef t_amt [2:0]      t_amts;

    typedef struct packed {
        t_key              id;
        t_amts             amt;
        logic [ProdW-1:0]  prod;
    } t_entry;

    typedef struct packed {
        logic             load_in;
        logic             norm;
        logic             srch_rd;
        logic             srch_upd;
        logic             shift_init;
        logic             shift_step;
        logic             put;
        logic             lk_rd;
        logic             lk_cap;
        logic             set_st;
        logic [StW-1:0]   st;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic op_lookup;
        logic full;
        logic srch_done;
        logic shift_done;
        logic in_range;
        logic match;
        logic out_free;
    } t_sts;

    // signed lexicographic compare, slot 0 most significant
    function automatic logic key_less(input t_key a, input t_key b);
        logic [3*IdW-1:0] ka;
        logic [3*IdW-1:0] kb;
        ka = {a[0] ^ ID_MSB, a[1] ^ ID_MSB, a[2] ^ ID_MSB};
        kb = {b[0] ^ ID_MSB, b[1] ^ ID_MSB, b[2] ^ ID_MSB};
        return ka < kb;
    endfunction

    function automatic t_entry swap_slots(input t_entry e, input int a, input int b);
        t_entry r;
        r        = e;
        r.id[a]  = e.id[b];
        r.amt[a] = e.amt[b];
        r.id[b]  = e.id[a];
        r.amt[b] = e.amt[a];
        return r;
    endfunction

    // three-element sort, then rotate leading empty slots to the end
    function automatic t_entry normalize(input t_entry e);
        t_entry r;
        r = e;
        if ($signed(r.id[0]) > $signed(r.id[1])) r = swap_slots(r, 0, 1);
        if ($signed(r.id[1]) > $signed(r.id[2])) r = swap_slots(r, 1, 2);
        if ($signed(r.id[0]) > $signed(r.id[1])) r = swap_slots(r, 0, 1);
        for (int p = 0; p < 2; p++) begin
            if (r.id[0] == ID_EMPTY) begin
                r = swap_slots(r, 0, 1);
                r = swap_slots(r, 1, 2);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/sorted_triple_key_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_triple_key_table_unit
// Table kept sorted on a normalized three-id key; insert with shift-up or
// binary-search lookup.
//
//   channel | dir | signals                          | beat
//   --------+-----+----------------------------------+----------------------
//   s       | in  | i_s_tvalid/o_s_tready/tdata/tuser| one insert or lookup
//   m       | out | o_m_tvalid/i_m_tready/tdata/tuser| one result
//
// One item at a time. Each binary-search probe is a read state then a compare
// state (RAM read is registered): at most ceil(log2(n+1)) probes for n entries.
// A lookup then compares the entry at the found position; an insert moves
// each entry above its position up one slot (n - position moves, through the
// single RAM write port), then writes the new entry. A full-table insert skips
// the search. Synchronous active-low reset empties the table at once.
// A result waiting on o_m_tready holds the next item only at its final step.
// ----------------------------------------------------------------------------
module sorted_triple_key_table_unit #(
    parameter int unsigned TABLE_DEPTH = sttk_pkg::DefTableDepth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // ingredient_first[12:0], amount_first[20:13], ingredient_second[33:21],
    // amount_second[41:34], ingredient_third[54:42], amount_third[62:55],
    // product_id[74:63], zero [79:75]
    input  logic [sttk_pkg::SDataW-1:0] i_s_tdata,
    // operation[0]
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // position[7:0], found_product[19:8], found_amount_first[27:20],
    // found_amount_second[35:28], found_amount_third[43:36], zero [47:44]
    output logic [sttk_pkg::MDataW-1:0] o_m_tdata,
    // status[1:0]
    output logic [sttk_pkg::StW-1:0]    o_m_tuser
);
    import sttk_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sttk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sttk_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ----- rtl/core/sttk_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttk_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sttk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sttk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttk_ctrl
// Sequencer: normalize, binary search, shift-up and write, or lookup compare.
// ----------------------------------------------------------------------------
module sttk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sttk_pkg::t_sts i_sts,
    output sttk_pkg::t_cmd o_cmd
);
    import sttk_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_FLUSH = 4'd5;
    localparam logic [3:0] S_PUT   = 4'd6;
    localparam logic [3:0] S_LRD   = 4'd7;
    localparam logic [3:0] S_LCMP  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_NORM;
                end
            end
            S_NORM: begin
                cmd.norm = 1'b1;
                if (!i_sts.op_lookup && i_sts.full) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_FULL;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                if (!i_sts.srch_done) begin
                    cmd.srch_rd = 1'b1;
                    n_state     = S_SCMP;
                end else if (!i_sts.op_lookup) begin
                    cmd.shift_init = 1'b1;
                    n_state        = S_SHIFT;
                end else if (i_sts.in_range) begin
                    n_state = S_LRD;
                end else begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NOT_FOUND;
                    n_state    = S_DONE;
                end
            end
            S_SCMP: begin
                cmd.srch_upd = 1'b1;
                n_state      = S_SRD;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_FLUSH;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FLUSH: begin
                // all shift writes have landed by now
                n_state = S_PUT;
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                cmd.set_st = 1'b1;
                cmd.st     = ST_INSERTED;
                n_state    = S_DONE;
            end
            S_LRD: begin
                cmd.lk_rd = 1'b1;
                n_state   = S_LCMP;
            end
            S_LCMP: begin
                cmd.set_st = 1'b1;
                if (i_sts.match) begin
                    cmd.lk_cap = 1'b1;
                    cmd.st     = ST_FOUND;
                end else begin
                    cmd.st = ST_NOT_FOUND;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ----- rtl/core/sttk_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttk_dp
// Datapath: item register, search bounds, entry count, shift pointer,
// table RAM and the output register.
// ----------------------------------------------------------------------------
module sttk_dp #(
    parameter int unsigned TABLE_DEPTH = sttk_pkg::DefTableDepth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sttk_pkg::t_cmd              i_cmd,
    output sttk_pkg::t_sts              o_sts,
    input  logic [sttk_pkg::SDataW-1:0] i_s_tdata,
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [sttk_pkg::MDataW-1:0] o_m_tdata,
    output logic [sttk_pkg::StW-1:0]    o_m_tuser
);
    import sttk_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned EW = $bits(t_entry);

    logic              r_op;
    t_entry            r_item;
    t_entry            r_hit;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_mid;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    logic              r_wr_pend;
    logic [AW-1:0]     r_wr_addr;
    logic [StW-1:0]    r_st;
    logic              r_m_valid;
    logic [MDataW-1:0] r_m_tdata;
    logic [StW-1:0]    r_m_tuser;

    logic [CW-1:0]      mid;
    logic [CW-1:0]      ptr_m1;
    t_entry             in_item;
    t_entry             rd_entry;
    logic [EW-1:0]      rd_bits;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    t_entry             wdata;
    logic [PosW+CW-1:0] pos_ext;
    logic [PosW-1:0]    pos;
    logic               has_pos;
    t_entry             res_src;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign ptr_m1 = r_ptr - CW'(1);

    // tdata: id0, amt0, id1, amt1, id2, amt2, product from bit 0 up
    always_comb begin
        in_item.id[0]  = i_s_tdata[12:0];
        in_item.amt[0] = i_s_tdata[20:13];
        in_item.id[1]  = i_s_tdata[33:21];
        in_item.amt[1] = i_s_tdata[41:34];
        in_item.id[2]  = i_s_tdata[54:42];
        in_item.amt[2] = i_s_tdata[62:55];
        in_item.prod   = i_s_tdata[74:63];
    end

    always_comb begin
        if (i_cmd.srch_rd) begin
            raddr = mid[AW-1:0];
        end else if (i_cmd.shift_step) begin
            raddr = ptr_m1[AW-1:0];
        end else begin
            raddr = r_lo[AW-1:0];
        end
    end

    // a pending shift write has priority; put only comes after the flush
    assign we    = r_wr_pend | i_cmd.put;
    assign waddr = r_wr_pend ? r_wr_addr : r_lo[AW-1:0];
    assign wdata = r_wr_pend ? rd_entry : r_item;

    sttk_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_bits)
    );

    assign rd_entry = t_entry'(rd_bits);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_s_tuser;
            r_item <= in_item;
        end
        if (i_cmd.norm) begin
            r_item <= normalize(r_item);
            r_lo   <= '0;
            r_hi   <= r_count;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= mid;
        end
        if (i_cmd.srch_upd) begin
            if (key_less(rd_entry.id, r_item.id)) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_ptr <= r_count;
        end else if (i_cmd.shift_step) begin
            r_ptr <= ptr_m1;
        end
        r_wr_addr <= r_ptr[AW-1:0];
        if (i_cmd.lk_cap) begin
            r_hit <= rd_entry;
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.shift_step;
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign pos_ext = {{PosW{1'b0}}, r_lo};
    assign has_pos = (r_st == ST_INSERTED) || (r_st == ST_FOUND);
    assign pos     = has_pos ? pos_ext[PosW-1:0] : '0;
    assign res_src = (r_st == ST_FOUND) ? r_hit : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tuser <= r_st;
            r_m_tdata <= {4'b0000, res_src.amt[2], res_src.amt[1], res_src.amt[0],
                          res_src.prod, pos};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    always_comb begin
        o_sts.op_lookup  = (r_op == OP_LOOKUP);
        o_sts.full       = (r_count == CW'(TABLE_DEPTH));
        o_sts.srch_done  = (r_lo >= r_hi);
        o_sts.shift_done = (r_ptr == r_lo);
        o_sts.in_range   = (r_lo < r_count);
        o_sts.match      = (rd_entry.id == r_item.id);
        o_sts.out_free   = !r_m_valid || i_m_tready;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_put_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> !r_wr_pend)
        else $error("new entry written while a shift write is pending");

    a_shift_above_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (CW'(r_wr_addr) > r_lo))
        else $error("shift write at or below insert position");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_m_valid)
        else $error("result load did not raise valid");

endmodule

// ----- tb/sttk_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttk_checker
// Watches both stream channels of the sorted triple-key table. Every accepted
// item is applied to a shadow table to work out its result; every result beat
// is compared field by field against the oldest result still owed.
// ----------------------------------------------------------------------------
module sttk_checker #(
    parameter int unsigned TABLE_DEPTH = sttk_pkg::DefTableDepth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [sttk_pkg::SDataW-1:0] i_s_tdata,
    input  logic                        i_s_tuser,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [sttk_pkg::MDataW-1:0] i_m_tdata,
    input  logic [sttk_pkg::StW-1:0]    i_m_tuser,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_inserts,
    output int                          o_full,
    output int                          o_hits,
    output int                          o_misses
);
    import sttk_pkg::*;

    typedef struct packed {
        logic [StW-1:0]   st;
        logic [PosW-1:0]  pos;
        logic [ProdW-1:0] prod;
        t_amts            amt;
    } t_result;

    t_key             shadow_key  [TABLE_DEPTH];
    t_amts            shadow_amt  [TABLE_DEPTH];
    logic [ProdW-1:0] shadow_prod [TABLE_DEPTH];
    int unsigned      shadow_count;

    t_result owed_results[$];
    int      reported;

    initial begin
        shadow_count = 0;
        reported     = 0;
        o_pending    = 0;
    end

    // stable sort on signed ids, then rotate leading empty slots to the end
    function automatic void order_ids(inout t_key id, inout t_amts amt);
        t_id  hold_id;
        t_amt hold_amt;
        for (int i = 1; i < 3; i++) begin
            for (int j = i; j > 0 && $signed(id[j-1]) > $signed(id[j]); j--) begin
                hold_id    = id[j];
                hold_amt   = amt[j];
                id[j]      = id[j-1];
                amt[j]     = amt[j-1];
                id[j-1]    = hold_id;
                amt[j-1]   = hold_amt;
            end
        end
        repeat (2) begin
            if (id[0] == ID_EMPTY) begin
                id  = {id[0], id[2], id[1]};
                amt = {amt[0], amt[2], amt[1]};
            end
        end
    endfunction

    function automatic logic key_below(input t_key a, input t_key b);
        for (int k = 0; k < 3; k++) begin
            if ($signed(a[k]) < $signed(b[k])) return 1'b1;
            if ($signed(a[k]) > $signed(b[k])) return 1'b0;
        end
        return 1'b0;
    endfunction

    task automatic apply_item(input logic op, input logic [SDataW-1:0] d, output t_result r);
        t_key        id;
        t_amts       amt;
        int unsigned pos;
        id[0]  = d[12:0];
        amt[0] = d[20:13];
        id[1]  = d[33:21];
        amt[1] = d[41:34];
        id[2]  = d[54:42];
        amt[2] = d[62:55];
        order_ids(id, amt);
        r = '0;
        // table is sorted: lower bound is the count of smaller keys
        pos = 0;
        while (pos < shadow_count && key_below(shadow_key[pos], id)) pos++;
        if (op == OP_INSERT) begin
            if (shadow_count >= TABLE_DEPTH) begin
                r.st = ST_FULL;
                o_full++;
            end else begin
                for (int unsigned i = shadow_count; i > pos; i--) begin
                    shadow_key[i]  = shadow_key[i-1];
                    shadow_amt[i]  = shadow_amt[i-1];
                    shadow_prod[i] = shadow_prod[i-1];
                end
                shadow_key[pos]  = id;
                shadow_amt[pos]  = amt;
                shadow_prod[pos] = d[74:63];
                shadow_count++;
                r.st  = ST_INSERTED;
                r.pos = pos[PosW-1:0];
                o_inserts++;
            end
        end else if (pos < shadow_count && shadow_key[pos] == id) begin
            r.st   = ST_FOUND;
            r.pos  = pos[PosW-1:0];
            r.prod = shadow_prod[pos];
            r.amt  = shadow_amt[pos];
            o_hits++;
        end else begin
            r.st = ST_NOT_FOUND;
            o_misses++;
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.st     = i_m_tuser;
        got.pos    = i_m_tdata[7:0];
        got.prod   = i_m_tdata[19:8];
        got.amt[0] = i_m_tdata[27:20];
        got.amt[1] = i_m_tdata[35:28];
        got.amt[2] = i_m_tdata[43:36];
        if (owed_results.size() == 0) begin
            o_fail_count++;
            if (reported < 10) begin
                reported++;
                $display("%0t: result beat with nothing owed: st=%0d pos=%0d prod=%h amt=%h",
                         $realtime, got.st, got.pos, got.prod, got.amt);
            end
        end else begin
            want = owed_results.pop_front();
            if (got.st !== want.st || got.pos !== want.pos || got.prod !== want.prod ||
                got.amt[0] !== want.amt[0] || got.amt[1] !== want.amt[1] ||
                got.amt[2] !== want.amt[2]) begin
                o_fail_count++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: mismatch exp st=%0d pos=%0d prod=%h amt=%h",
                             $realtime, want.st, want.pos, want.prod, want.amt);
                    $display("%0t:          got st=%0d pos=%0d prod=%h amt=%h",
                             $realtime, got.st, got.pos, got.prod, got.amt);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                apply_item(i_s_tuser, i_s_tdata, r);
                owed_results.push_back(r);
            end
            if (i_m_tvalid && i_m_tready) check_result();
            o_pending <= owed_results.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted triple-key table: a directed set of inserts and
// lookups on edge-case keys, then random traffic that fills the table and
// keeps probing it, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import sttk_pkg::*;

    localparam int unsigned RandomItems = 880;
    localparam int unsigned CycleLimit  = 2000000;
    localparam int          HoldAfter   = 150;
    localparam int          HoldCycles  = 600;

    logic              i_clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [SDataW-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [MDataW-1:0] m_tdata;
    logic [StW-1:0]    m_tuser;

    int fail_count;
    int pending;
    int n_inserts;
    int n_full;
    int n_hits;
    int n_misses;

    bit   quiet;
    t_key stored_keys[$];

    sorted_triple_key_table_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    sttk_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_inserts    (n_inserts),
        .o_full       (n_full),
        .o_hits       (n_hits),
        .o_misses     (n_misses)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_key key3(input int a, input int b, input int c);
        return {t_id'(c), t_id'(b), t_id'(a)};
    endfunction

    function automatic t_amts amt3(input int a, input int b, input int c);
        return {t_amt'(c), t_amt'(b), t_amt'(a)};
    endfunction

    function automatic t_id pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return ID_EMPTY;
        if (r < 60) return t_id'($urandom_range(0, 31));
        if (r < 90) return t_id'($urandom_range(0, 4095));
        return t_id'($urandom);
    endfunction

    function automatic t_key shuffle_key(input t_key k);
        t_key r;
        r = k;
        repeat ($urandom_range(0, 2)) r = {r[0], r[2], r[1]};
        if ($urandom_range(0, 1) == 1) r = {r[2], r[0], r[1]};
        return r;
    endfunction

    // returns at the edge where the beat is taken
    task automatic send_item(input logic op, input t_key id, input t_amts amt,
                             input logic [ProdW-1:0] prod);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, prod, amt[2], id[2], amt[1], id[1], amt[0], id[0]};
        do @(posedge i_clk); while (!s_tready);
        if (op == OP_INSERT) stored_keys.push_back(id);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        int beats;
        beats = 0;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            // one long hold so the block backs up onto its input
            if (beats == HoldAfter) stall = HoldCycles;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            beats++;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic op;
        t_key id;
        quiet    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_INSERT;
        s_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table miss, id order and empty-slot handling,
        // duplicates, ids below -1, extreme ids, amounts and products
        send_item(OP_LOOKUP, key3(5, 1, 3), amt3(0, 0, 0), 12'd0);
        send_item(OP_INSERT, key3(30, 20, 10), amt3(1, 2, 3), 12'd100);
        send_item(OP_LOOKUP, key3(20, 10, 30), amt3(9, 9, 9), 12'd0);
        send_item(OP_INSERT, key3(-1, -1, -1), amt3(255, 255, 255), 12'hFFF);
        send_item(OP_INSERT, key3(-1, 7, -1), amt3(10, 20, 30), 12'd7);
        send_item(OP_INSERT, key3(4095, 4095, 4095), amt3(0, 0, 0), 12'd0);
        send_item(OP_INSERT, key3(0, 0, 0), amt3(4, 5, 6), 12'd1);
        send_item(OP_INSERT, key3(0, 0, 0), amt3(7, 8, 9), 12'd2);
        send_item(OP_INSERT, key3(-4096, -2, 5), amt3(11, 12, 13), 12'd3);
        send_item(OP_INSERT, key3(-1, -4096, 3), amt3(14, 15, 16), 12'd4);
        send_item(OP_INSERT, key3(9, 9, 9), amt3(1, 2, 3), 12'd5);
        send_item(OP_LOOKUP, key3(9, 9, 9), amt3(0, 0, 0), 12'd0);
        send_item(OP_LOOKUP, key3(-1, -1, -1), amt3(0, 0, 0), 12'd0);
        send_item(OP_LOOKUP, key3(-1, -1, 7), amt3(255, 255, 255), 12'hFFF);
        send_item(OP_LOOKUP, key3(4095, 4095, 4094), amt3(0, 0, 0), 12'd0);
        send_item(OP_LOOKUP, key3(0, 0, 0), amt3(1, 1, 1), 12'd0);
        send_item(OP_LOOKUP, key3(5, -2, -4096), amt3(0, 0, 0), 12'd0);
        send_item(OP_LOOKUP, key3(3, -1, -4096), amt3(0, 0, 0), 12'd0);
        send_item(OP_INSERT, key3(4095, -1, 0), amt3(255, 0, 255), 12'hFFF);
        send_item(OP_LOOKUP, key3(0, 4095, -1), amt3(0, 0, 0), 12'd0);
        send_item(OP_INSERT, key3(-1, -1, 4095), amt3(128, 64, 32), 12'h800);
        send_item(OP_LOOKUP, key3(4095, -1, -1), amt3(0, 0, 0), 12'd0);
        drain();

        // random: inserts fill the table part way through, lookups mostly
        // aim at stored keys in scrambled slot order
        for (int n = 0; n < RandomItems; n++) begin
            if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (n == 280 || n == 600) drain();
            op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
            if (stored_keys.size() > 0 &&
                $urandom_range(0, 99) < ((op == OP_INSERT) ? 25 : 70)) begin
                id = shuffle_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            end else begin
                id = {pick_id(), pick_id(), pick_id()};
            end
            send_item(op, id, t_amts'({$urandom, $urandom}), ProdW'($urandom));
        end

        drain();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d beats: %0d inserts stored, %0d refused on a full table,",
                 22 + RandomItems, n_inserts, n_full);
        $display("%0d lookups hit and %0d missed; %0d mismatches", n_hits, n_misses,
                 fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sttk_pkg.sv
rtl/core/sttk_ram.sv
rtl/core/sttk_ctrl.sv
rtl/core/sttk_dp.sv
rtl/core/sorted_triple_key_table_unit.sv
tb/sttk_checker.sv
tb/tb.sv
